// ===== sv/wvt_pkg.sv =====
// Shared types and constants of the wireframe vertex transform.
package wvt_pkg;

  localparam int MODEL_W  = 12;
  localparam int POS_W    = 12;
  localparam int TURN_W   = 16;
  localparam int SCALE_W  = 9;
  localparam int COLOUR_W = 4;
  localparam int COORD_W  = 14;

  localparam int ROT_W    = 31;
  localparam int Z_W      = 31;
  localparam int STAGES   = 16;
  localparam int STAGE_W  = 4;

  localparam int K_W      = 26;
  localparam int DIGITS   = K_W / 2;
  localparam int DIGIT_W  = 4;
  localparam int PROD_SHIFT = 44;

  localparam logic [K_W-1:0] GAIN_Q16 = K_W'(39797);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic signed [Z_W-1:0] ATAN_TURN [STAGES] = '{
    31'sd536870912, 31'sd316933406, 31'sd167458907, 31'sd85004756,
    31'sd42667331,  31'sd21354465,  31'sd10679838,  31'sd5340245,
    31'sd2670163,   31'sd1335087,   31'sd667544,    31'sd333772,
    31'sd166886,    31'sd83443,     31'sd41722,     31'sd20861
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_SCALE,
    ST_EMIT
  } wvt_state_t;

endpackage

// ===== sv/wvt_cordic.sv =====
// Quarter-turn fold and sixteen-iteration CORDIC rotator.
module wvt_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [wvt_pkg::MODEL_W-1:0]  model_x,
  input  logic signed [wvt_pkg::MODEL_W-1:0]  model_y,
  input  logic        [wvt_pkg::TURN_W-1:0]   turn,
  output logic                                done,
  output logic signed [wvt_pkg::ROT_W-1:0]    rot_x,
  output logic signed [wvt_pkg::ROT_W-1:0]    rot_y
);
  import wvt_pkg::*;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  logic                      busy;
  logic [STAGE_W-1:0]        cnt;
  logic signed [ROT_W-1:0]   x, y;
  logic signed [Z_W-1:0]     z;

  logic [TURN_W-1:0]         tq, resid;
  quad_t                     quad;
  logic signed [MODEL_W:0]   mx, my, xq, yq;
  logic signed [ROT_W-1:0]   x_init, y_init, dx, dy, x_next, y_next;
  logic signed [Z_W-1:0]     z_init, z_next;

  always_comb begin
    tq    = turn + TURN_W'(16'h2000);
    quad  = quad_t'(tq[TURN_W-1:TURN_W-2]);
    resid = turn - {tq[TURN_W-1:TURN_W-2], {(TURN_W-2){1'b0}}};
    mx    = {model_x[MODEL_W-1], model_x};
    my    = {model_y[MODEL_W-1], model_y};
    unique case (quad)
      QUAD_1: begin
        xq = -my;
        yq = mx;
      end
      QUAD_2: begin
        xq = -mx;
        yq = -my;
      end
      QUAD_3: begin
        xq = my;
        yq = -mx;
      end
      default: begin
        xq = mx;
        yq = my;
      end
    endcase
    x_init = {{(ROT_W-MODEL_W-17){xq[MODEL_W]}}, xq, 16'b0};
    y_init = {{(ROT_W-MODEL_W-17){yq[MODEL_W]}}, yq, 16'b0};
    z_init = {resid[TURN_W-2:0], 16'b0};

    dx = y >>> cnt;
    dy = x >>> cnt;
    if (!z[Z_W-1]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - ATAN_TURN[cnt];
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + ATAN_TURN[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == STAGE_W'(STAGES - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STAGE_W'(STAGES - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x_init;
      y <= y_init;
      z <= z_init;
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  assign rot_x = x;
  assign rot_y = y;

endmodule

// ===== sv/wvt_scale_mul.sv =====
// Two-bit-per-cycle serial multiplier with rounding, offset and saturation.
module wvt_scale_mul #(
  parameter int FRAC_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [wvt_pkg::ROT_W-1:0]    rot,
  input  logic        [wvt_pkg::K_W-1:0]      k,
  input  logic        [wvt_pkg::POS_W-1:0]    pos,
  output logic                                done,
  output logic signed [wvt_pkg::COORD_W-1:0]  coord
);
  import wvt_pkg::*;

  localparam int RND_W = ROT_W + 1;
  localparam int T_W   = ROT_W + 2;
  localparam int R     = PROD_SHIFT - FRAC_BITS - K_W;
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (R - 1);

  logic                      busy;
  logic [DIGIT_W-1:0]        cnt;
  logic signed [ROT_W-1:0]   rot_q;
  logic signed [ROT_W-1:0]   acc;
  logic [K_W-1:0]            k_sh;

  logic signed [T_W-1:0]     t;
  logic signed [RND_W-1:0]   rnd, v;
  logic [RND_W-COORD_W:0]    hi;
  logic signed [COORD_W-1:0] coord_next;

  always_comb begin
    t = {{2{acc[ROT_W-1]}}, acc};
    if (k_sh[0]) begin
      t = t + {{2{rot_q[ROT_W-1]}}, rot_q};
    end
    if (k_sh[1]) begin
      t = t + {rot_q[ROT_W-1], rot_q, 1'b0};
    end

    rnd = $signed({acc[ROT_W-1], acc}) + HALF;
    v   = (rnd >>> R) + $signed({{(RND_W-POS_W){1'b0}}, pos});
    hi  = v[RND_W-1:COORD_W-1];
    if (&hi || ~|hi) begin
      coord_next = v[COORD_W-1:0];
    end else if (v[RND_W-1]) begin
      coord_next = COORD_MIN;
    end else begin
      coord_next = COORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIGIT_W'(DIGITS));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIGIT_W'(DIGITS)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rot_q <= rot;
      acc   <= '0;
      k_sh  <= k;
    end else if (busy) begin
      if (cnt == DIGIT_W'(DIGITS)) begin
        coord <= coord_next;
      end else begin
        acc  <= t[T_W-1:2];
        k_sh <= {2'b00, k_sh[K_W-1:2]};
      end
    end
  end

endmodule

// ===== sv/wireframe_vertex_transform.sv =====
// Top level: vertex sequencing, segment assembly and output registers.
// Each accepted item runs through the 16 CORDIC iterations, then the 13 two-bit digits
// of the scaling multipliers, one after the other; the item's segment, if any, is then
// registered once the output is free. A new item is taken only when the block is idle again.
// A closing segment follows in the cycle after the segment before it is taken.
// Synchronous reset empties the output and makes the block wait for a first vertex.
module wireframe_vertex_transform #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [wvt_pkg::MODEL_W-1:0]   model_x,
  input  logic signed [wvt_pkg::MODEL_W-1:0]   model_y,
  input  logic        [wvt_pkg::POS_W-1:0]     pos_x,
  input  logic        [wvt_pkg::POS_W-1:0]     pos_y,
  input  logic        [wvt_pkg::TURN_W-1:0]    turn,
  input  logic        [wvt_pkg::SCALE_W-1:0]   scale,
  input  logic        [wvt_pkg::COLOUR_W-1:0]  colour,
  input  logic                                 last_vertex,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wvt_pkg::COORD_W-1:0]   start_x,
  output logic signed [wvt_pkg::COORD_W-1:0]   start_y,
  output logic signed [wvt_pkg::COORD_W-1:0]   end_x,
  output logic signed [wvt_pkg::COORD_W-1:0]   end_y,
  output logic        [wvt_pkg::COLOUR_W-1:0]  seg_colour,
  output logic                                 last_segment
);
  import wvt_pkg::*;

  localparam int DROP = (ANGLE_BITS < TURN_W) ? TURN_W - ANGLE_BITS : 0;
  localparam logic [TURN_W-1:0] TURN_MASK = {TURN_W{1'b1}} << DROP;

  wvt_state_t state, state_next;

  logic [POS_W-1:0]          pos_x_q, pos_y_q;
  logic [COLOUR_W-1:0]       colour_q, cls_colour;
  logic                      last_q;
  logic [K_W-1:0]            k_q;

  logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
  logic                      in_model;
  logic                      cls_valid;

  logic                      accept, rot_done, mul_start, x_done, y_done, out_free, fin_go;
  logic                      seg_go;
  logic signed [ROT_W-1:0]   rot_x, rot_y;
  logic signed [COORD_W-1:0] cx, cy;

  assign accept   = in_valid && in_ready;
  assign out_free = !cls_valid && (!out_valid || out_ready);
  assign seg_go   = fin_go && (in_model || last_q);

  wvt_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .model_x (model_x),
    .model_y (model_y),
    .turn    (turn & TURN_MASK),
    .done    (rot_done),
    .rot_x   (rot_x),
    .rot_y   (rot_y)
  );

  wvt_scale_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_x (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .rot   (rot_x),
    .k     (k_q),
    .pos   (pos_x_q),
    .done  (x_done),
    .coord (cx)
  );

  wvt_scale_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_y (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .rot   (rot_y),
    .k     (k_q),
    .pos   (pos_y_q),
    .done  (y_done),
    .coord (cy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_start  = 1'b0;
    fin_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        if (rot_done) begin
          mul_start  = 1'b1;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (x_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          fin_go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x_q  <= pos_x;
      pos_y_q  <= pos_y;
      colour_q <= colour;
      last_q   <= last_vertex;
      k_q      <= GAIN_Q16 * K_W'(scale);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cls_valid <= 1'b0;
      in_model  <= 1'b0;
      first_x   <= '0;
      first_y   <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (cls_valid) begin
          cls_valid    <= 1'b0;
          start_x      <= prev_x;
          start_y      <= prev_y;
          end_x        <= first_x;
          end_y        <= first_y;
          seg_colour   <= cls_colour;
          last_segment <= 1'b1;
        end else if (!seg_go) begin
          out_valid <= 1'b0;
        end
      end
      if (fin_go) begin
        prev_x <= cx;
        prev_y <= cy;
        if (!in_model) begin
          first_x  <= cx;
          first_y  <= cy;
          in_model <= !last_q;
          if (last_q) begin
            out_valid    <= 1'b1;
            start_x      <= cx;
            start_y      <= cy;
            end_x        <= cx;
            end_y        <= cy;
            seg_colour   <= colour_q;
            last_segment <= 1'b1;
          end
        end else begin
          out_valid    <= 1'b1;
          start_x      <= prev_x;
          start_y      <= prev_y;
          end_x        <= cx;
          end_y        <= cy;
          seg_colour   <= colour_q;
          last_segment <= 1'b0;
          if (last_q) begin
            in_model   <= 1'b0;
            cls_valid  <= 1'b1;
            cls_colour <= colour_q;
          end
        end
      end
    end
  end

  a_cls_behind_out: assert property (@(posedge clk) disable iff (rst)
    cls_valid |-> out_valid)
    else $error("closing segment pending without a segment on the output");

  a_cls_model_closed: assert property (@(posedge clk) disable iff (rst)
    cls_valid |-> !in_model)
    else $error("closing segment pending while a model is still open");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    x_done == y_done)
    else $error("x and y multipliers out of step");

  a_rot_done_state: assert property (@(posedge clk) disable iff (rst)
    rot_done |-> state == ST_ROTATE)
    else $error("rotator finished outside the rotate state");

  a_emit_after_scale: assert property (@(posedge clk) disable iff (rst)
    fin_go |-> $past(state) == ST_SCALE || $past(state) == ST_EMIT)
    else $error("segment assembly without a finished scaling pass");

endmodule
